// File: rtl/sg3_pkg.sv
// ----------------------------------------------------------------------------
// sg3_pkg: shared types and constants for the 3x3 sobel gradient block
// Pixel and register widths, register map codes, window type, config type.
// ----------------------------------------------------------------------------
package sg3_pkg;

   // payload widths
   localparam int PIX_W    = 8;
   localparam int GRAD_W   = 8;
   localparam int DIM_W    = 12;
   localparam int CCOL_W   = 11;
   localparam int SUM_W    = PIX_W + 2;

   // centre tap weight of the sobel kernel
   localparam logic [1:0] CENTER_WEIGHT = 2'd2;

   // register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register index codes (paddr bit 2)
   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   // register reset values
   localparam logic [DIM_W-1:0] IMAGE_WIDTH_RST  = 12'd1920;
   localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RST = 12'd1080;

   // frame geometry as programmed
   typedef struct packed {
      logic [DIM_W-1:0] image_width;
      logic [DIM_W-1:0] image_height;
   } cfg_type;

   // two previous window columns: left (two back) and centre (one back)
   typedef struct packed {
      logic [PIX_W-1:0] lt;
      logic [PIX_W-1:0] lm;
      logic [PIX_W-1:0] lb;
      logic [PIX_W-1:0] ct;
      logic [PIX_W-1:0] cm;
      logic [PIX_W-1:0] cb;
   } window_type;

endpackage

// File: rtl/sobel_gradient_3x3.sv
// ----------------------------------------------------------------------------
// sobel_gradient_3x3: streaming 3x3 sobel gradient over a raster pixel stream
// Pipeline: two register stages, the input stage and the result register; a
// result is registered when the beat completing its window leaves the input stage.
// Throughput: one pixel per cycle; each line store reads the new column while the
// previous beat writes its own, so the input stalls only while a result is held.
// Reset: counters, window, valid flags cleared; line stores are not cleared.
// ----------------------------------------------------------------------------
module sobel_gradient_3x3 #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // pixel channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [sg3_pkg::PIX_W-1:0]            req_pixel,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [sg3_pkg::GRAD_W-1:0]           rsp_grad_x,
   output logic [sg3_pkg::GRAD_W-1:0]           rsp_grad_y,
   output logic [sg3_pkg::DIM_W-1:0]            rsp_center_row,
   output logic [sg3_pkg::CCOL_W-1:0]           rsp_center_col,
   output logic                                 rsp_frame_last,
   // register port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [sg3_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [sg3_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [sg3_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                 csr_pready
);

   localparam int DIM_W  = sg3_pkg::DIM_W;
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int MW_W   = $clog2(MAX_WIDTH + 1);
   localparam int EW     = (MW_W > DIM_W) ? MW_W : DIM_W;
   localparam int CX_W   = (COL_W > sg3_pkg::CCOL_W) ? COL_W : sg3_pkg::CCOL_W;

   sg3_pkg::cfg_type     cfg;
   logic                 restart;

   logic [EW-1:0]        w_eff;
   logic [DIM_W-1:0]     h_eff;

   logic [COL_W-1:0]     col_count_ff;
   logic [DIM_W-1:0]     row_count_ff;
   logic                 col_wrap;
   logic                 row_wrap;
   logic                 req_accept;

   logic                 s1_valid_ff;
   logic [sg3_pkg::PIX_W-1:0] s1_pixel_ff;
   logic [COL_W-1:0]     s1_col_ff;
   logic [DIM_W-1:0]     s1_row_ff;
   logic                 s1_interior_ff;
   logic                 s1_last_ff;
   logic                 out_free;
   logic                 s1_adv;

   logic [sg3_pkg::PIX_W-1:0] top_pix;
   logic [sg3_pkg::PIX_W-1:0] mid_pix;
   sg3_pkg::window_type  win_ff;
   logic [sg3_pkg::GRAD_W-1:0] grad_x;
   logic [sg3_pkg::GRAD_W-1:0] grad_y;
   logic [CX_W-1:0]      ccol_full;

   logic                 rsp_valid_ff;
   logic [sg3_pkg::GRAD_W-1:0] rsp_grad_x_ff;
   logic [sg3_pkg::GRAD_W-1:0] rsp_grad_y_ff;
   logic [DIM_W-1:0]     rsp_center_row_ff;
   logic [sg3_pkg::CCOL_W-1:0] rsp_center_col_ff;
   logic                 rsp_frame_last_ff;

   // register block
   sg3_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .restart     (restart)
   );

   // effective frame size: width clamped to the line store, zero acts as one
   always_comb begin
      if (EW'(cfg.image_width) > EW'(MAX_WIDTH)) begin
         w_eff = EW'(MAX_WIDTH);
      end else if (cfg.image_width == '0) begin
         w_eff = EW'(1);
      end else begin
         w_eff = EW'(cfg.image_width);
      end
      h_eff = (cfg.image_height == '0) ? DIM_W'(1) : cfg.image_height;
   end

   // handshake
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_adv     = s1_valid_ff && out_free;
   assign req_stall  = s1_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   // raster position of the next incoming pixel
   assign col_wrap = (EW'(col_count_ff) + EW'(1)) >= w_eff;
   assign row_wrap = ((DIM_W+1)'(row_count_ff) + (DIM_W+1)'(1)) >= (DIM_W+1)'(h_eff);

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
      end else if (req_accept) begin
         if (col_wrap) begin
            col_count_ff <= '0;
            row_count_ff <= row_wrap ? '0 : row_count_ff + DIM_W'(1);
         end else begin
            col_count_ff <= col_count_ff + COL_W'(1);
         end
      end
   end

   // input stage: pixel with its position, line store reads issued alongside
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pixel_ff    <= req_pixel;
         s1_col_ff      <= col_count_ff;
         s1_row_ff      <= row_count_ff;
         s1_interior_ff <= (row_count_ff >= DIM_W'(2)) && (col_count_ff >= COL_W'(2));
         s1_last_ff     <= ((DIM_W+1)'(row_count_ff) + (DIM_W+1)'(1) == (DIM_W+1)'(h_eff))
                           && (EW'(col_count_ff) + EW'(1) == w_eff);
      end
   end

   // line stores: upper takes the old middle row, middle takes the new pixel
   sg3_line_store #(
      .DEPTH (MAX_WIDTH)
   ) u_store_upper (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (mid_pix),
      .rd_en   (req_accept),
      .rd_addr (col_count_ff),
      .rd_data (top_pix)
   );

   sg3_line_store #(
      .DEPTH (MAX_WIDTH)
   ) u_store_middle (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (s1_pixel_ff),
      .rd_en   (req_accept),
      .rd_addr (col_count_ff),
      .rd_data (mid_pix)
   );

   // window columns shift left on every beat that leaves the input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (s1_adv) begin
         win_ff.lt <= win_ff.ct;
         win_ff.lm <= win_ff.cm;
         win_ff.lb <= win_ff.cb;
         win_ff.ct <= top_pix;
         win_ff.cm <= mid_pix;
         win_ff.cb <= s1_pixel_ff;
      end
   end

   // gradient arithmetic
   sg3_kernel u_kernel (
      .win    (win_ff),
      .top    (top_pix),
      .mid    (mid_pix),
      .bot    (s1_pixel_ff),
      .grad_x (grad_x),
      .grad_y (grad_y)
   );

   assign ccol_full = CX_W'(s1_col_ff) - CX_W'(1);

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= s1_interior_ff;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_interior_ff) begin
         rsp_grad_x_ff     <= grad_x;
         rsp_grad_y_ff     <= grad_y;
         rsp_center_row_ff <= s1_row_ff - DIM_W'(1);
         rsp_center_col_ff <= ccol_full[sg3_pkg::CCOL_W-1:0];
         rsp_frame_last_ff <= s1_last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_grad_x     = rsp_grad_x_ff;
   assign rsp_grad_y     = rsp_grad_y_ff;
   assign rsp_center_row = rsp_center_row_ff;
   assign rsp_center_col = rsp_center_col_ff;
   assign rsp_frame_last = rsp_frame_last_ff;

   // checks
   a_interior_gives_result: assert property (
      @(posedge clock) disable iff (reset)
      s1_adv && s1_interior_ff |=> rsp_valid_ff
   ) else $error("interior pixel left the input stage without a result");

   a_col_in_range: assert property (
      @(posedge clock) disable iff (reset)
      EW'(col_count_ff) < w_eff
   ) else $error("column counter beyond the effective row length");

   a_stall_only_when_full: assert property (
      @(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid_ff
   ) else $error("input stalled while the pipeline has room");

endmodule

// File: rtl/sg3_csr.sv
// ----------------------------------------------------------------------------
// sg3_csr: configuration registers
// APB-style slave holding image width and height; a write restarts the frame.
// ----------------------------------------------------------------------------
module sg3_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [sg3_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [sg3_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [sg3_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                 csr_pready,
   output sg3_pkg::cfg_type                     cfg,
   output logic                                 restart
);

   sg3_pkg::cfg_type cfg_ff;
   logic             wr_en;
   logic             reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = csr_paddr[2];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width  <= sg3_pkg::IMAGE_WIDTH_RST;
         cfg_ff.image_height <= sg3_pkg::IMAGE_HEIGHT_RST;
      end else if (wr_en) begin
         case (reg_sel)
            sg3_pkg::REG_IMAGE_WIDTH:
               cfg_ff.image_width <= csr_pwdata[sg3_pkg::DIM_W-1:0];
            sg3_pkg::REG_IMAGE_HEIGHT:
               cfg_ff.image_height <= csr_pwdata[sg3_pkg::DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (reg_sel)
         sg3_pkg::REG_IMAGE_WIDTH:
            csr_prdata = sg3_pkg::CSR_DATA_W'(cfg_ff.image_width);
         sg3_pkg::REG_IMAGE_HEIGHT:
            csr_prdata = sg3_pkg::CSR_DATA_W'(cfg_ff.image_height);
         default:
            csr_prdata = '0;
      endcase
   end

   assign cfg     = cfg_ff;
   assign restart = wr_en;

endmodule

// File: rtl/sg3_line_store.sv
// ----------------------------------------------------------------------------
// sg3_line_store: one row of pixel storage
// Single write port, registered read port; a read of the address being
// written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module sg3_line_store #(
   parameter int DEPTH = 2048
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(DEPTH)-1:0]       wr_addr,
   input  logic [sg3_pkg::PIX_W-1:0]      wr_data,
   input  logic                           rd_en,
   input  logic [$clog2(DEPTH)-1:0]       rd_addr,
   output logic [sg3_pkg::PIX_W-1:0]      rd_data
);

   logic [sg3_pkg::PIX_W-1:0] mem_ff [DEPTH];
   logic [sg3_pkg::PIX_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port with write bypass
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/sg3_kernel.sv
// ----------------------------------------------------------------------------
// sg3_kernel: sobel gradient arithmetic
// Forms both 3x3 gradients from the stored columns and the new right column,
// keeping the low 8 bits of each signed sum.
// ----------------------------------------------------------------------------
module sg3_kernel (
   input  sg3_pkg::window_type               win,
   input  logic [sg3_pkg::PIX_W-1:0]         top,
   input  logic [sg3_pkg::PIX_W-1:0]         mid,
   input  logic [sg3_pkg::PIX_W-1:0]         bot,
   output logic [sg3_pkg::GRAD_W-1:0]        grad_x,
   output logic [sg3_pkg::GRAD_W-1:0]        grad_y
);

   localparam int SW = sg3_pkg::SUM_W;

   logic [SW-1:0] right_sum;
   logic [SW-1:0] left_sum;
   logic [SW-1:0] upper_sum;
   logic [SW-1:0] lower_sum;
   logic [SW-1:0] dx;
   logic [SW-1:0] dy;

   // column sums for the horizontal gradient
   assign right_sum = SW'(top) + SW'(sg3_pkg::CENTER_WEIGHT) * SW'(mid) + SW'(bot);
   assign left_sum  = SW'(win.lt) + SW'(sg3_pkg::CENTER_WEIGHT) * SW'(win.lm) + SW'(win.lb);

   // row sums for the vertical gradient
   assign upper_sum = SW'(win.lt) + SW'(sg3_pkg::CENTER_WEIGHT) * SW'(win.ct) + SW'(top);
   assign lower_sum = SW'(win.lb) + SW'(sg3_pkg::CENTER_WEIGHT) * SW'(win.cb) + SW'(bot);

   // wrap-around differences, low bits kept
   assign dx = right_sum - left_sum;
   assign dy = upper_sum - lower_sum;

   assign grad_x = dx[sg3_pkg::GRAD_W-1:0];
   assign grad_y = dy[sg3_pkg::GRAD_W-1:0];

endmodule

// File: bench/tb_sobel_gradient_3x3.sv
// ----------------------------------------------------------------------------
// tb_sobel_gradient_3x3: self-checking bench for the streaming sobel block
// Streams raster pixels through the block under several programmed frame
// sizes and predicts every gradient beat with its own line stores and window.
// Covers reset geometry, tiny and degenerate sizes, frames cut short, a width
// past the line store, a tall frame, and back-pressure on both sides.
// ----------------------------------------------------------------------------
module tb_sobel_gradient_3x3;

   localparam int MAX_WIDTH      = 2048;
   localparam int RANDOM_PIXELS  = 400;
   localparam int HOLD_CYCLES    = 200;
   localparam int SETTLE_CYCLES  = 8;
   localparam int CYCLE_LIMIT    = 600000;
   localparam int REPORT_CAP     = 50;

   // one gradient beat as seen on the result channel
   typedef struct packed {
      logic [sg3_pkg::GRAD_W-1:0] grad_x;
      logic [sg3_pkg::GRAD_W-1:0] grad_y;
      logic [sg3_pkg::DIM_W-1:0]  center_row;
      logic [sg3_pkg::CCOL_W-1:0] center_col;
      logic                       frame_last;
   } gradient_result_type;

   // predicts the gradient beats and checks them in order
   class sobel_scoreboard_type;
      logic [sg3_pkg::PIX_W-1:0]  upper_line [MAX_WIDTH];
      logic [sg3_pkg::PIX_W-1:0]  middle_line [MAX_WIDTH];
      sg3_pkg::window_type        window;
      logic [sg3_pkg::DIM_W-1:0]  row_idx;
      logic [sg3_pkg::CCOL_W-1:0] col_idx;
      sg3_pkg::cfg_type           geometry;
      gradient_result_type        pending_gradients [$];
      int                         pixels_taken;
      int                         gradients_checked;
      int                         mismatch_count;

      function new();
         foreach (upper_line[i]) begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
         end
         window                = '0;
         row_idx               = '0;
         col_idx               = '0;
         geometry.image_width  = sg3_pkg::IMAGE_WIDTH_RST;
         geometry.image_height = sg3_pkg::IMAGE_HEIGHT_RST;
         pixels_taken          = 0;
         gradients_checked     = 0;
         mismatch_count        = 0;
      endfunction

      task report_mismatch(string msg);
         mismatch_count++;
         if (mismatch_count <= REPORT_CAP) begin
            $display("MISMATCH @%0t: %s", $realtime, msg);
         end
      endtask

      // row length in use: clamped to the line store, zero acts as one
      function int row_length();
         int w;
         w = geometry.image_width;
         if (w > MAX_WIDTH) w = MAX_WIDTH;
         if (w == 0) w = 1;
         return w;
      endfunction

      function int frame_rows();
         return (geometry.image_height == 0) ? 1 : int'(geometry.image_height);
      endfunction

      // any register write restarts the frame, stores and window are kept
      function void write_register(logic sel, logic [sg3_pkg::CSR_DATA_W-1:0] value);
         if (sel == sg3_pkg::REG_IMAGE_WIDTH) begin
            geometry.image_width = value[sg3_pkg::DIM_W-1:0];
         end else begin
            geometry.image_height = value[sg3_pkg::DIM_W-1:0];
         end
         row_idx = '0;
         col_idx = '0;
      endfunction

      // one accepted pixel beat: update stores and window, maybe expect a beat
      function void take_pixel(logic [sg3_pkg::PIX_W-1:0] pix);
         int w, h, r, c, top, mid, bot, gx, gy, wt;
         gradient_result_type g;
         w   = row_length();
         h   = frame_rows();
         r   = row_idx;
         c   = col_idx;
         wt  = int'(sg3_pkg::CENTER_WEIGHT);
         top = upper_line[c];
         mid = middle_line[c];
         bot = pix;
         upper_line[c]  = sg3_pkg::PIX_W'(mid);
         middle_line[c] = pix;

         // window complete once two rows and two columns are behind
         if (r >= 2 && c >= 2) begin
            gy = (int'(window.lt) + wt * int'(window.ct) + top)
               - (int'(window.lb) + wt * int'(window.cb) + bot);
            gx = (top + wt * mid + bot)
               - (int'(window.lt) + wt * int'(window.lm) + int'(window.lb));
            g.grad_x     = sg3_pkg::GRAD_W'(gx);
            g.grad_y     = sg3_pkg::GRAD_W'(gy);
            g.center_row = sg3_pkg::DIM_W'(r - 1);
            g.center_col = sg3_pkg::CCOL_W'(c - 1);
            g.frame_last = (r + 1 == h) && (c + 1 == w);
            pending_gradients.push_back(g);
         end

         // shift the window one column
         window.lt = window.ct;
         window.lm = window.cm;
         window.lb = window.cb;
         window.ct = sg3_pkg::PIX_W'(top);
         window.cm = sg3_pkg::PIX_W'(mid);
         window.cb = pix;

         // raster position of the next pixel
         if (c + 1 >= w) begin
            col_idx = '0;
            row_idx = (r + 1 >= h) ? '0 : sg3_pkg::DIM_W'(r + 1);
         end else begin
            col_idx = sg3_pkg::CCOL_W'(c + 1);
         end
         pixels_taken++;
      endfunction

      task check_gradient(gradient_result_type seen);
         gradient_result_type want;
         if (pending_gradients.size() == 0) begin
            report_mismatch($sformatf("gradient beat with nothing expected: row %0d col %0d",
                                      seen.center_row, seen.center_col));
            return;
         end
         want = pending_gradients.pop_front();
         gradients_checked++;
         if (seen.grad_x !== want.grad_x || seen.grad_y !== want.grad_y
             || seen.center_row !== want.center_row || seen.center_col !== want.center_col
             || seen.frame_last !== want.frame_last) begin
            report_mismatch($sformatf(
               "got gx %h gy %h r %0d c %0d last %b, want gx %h gy %h r %0d c %0d last %b",
               seen.grad_x, seen.grad_y, seen.center_row, seen.center_col, seen.frame_last,
               want.grad_x, want.grad_y, want.center_row, want.center_col,
               want.frame_last));
         end
      endtask
   endclass

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [sg3_pkg::PIX_W-1:0]      req_pixel = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [sg3_pkg::GRAD_W-1:0]     rsp_grad_x;
   logic [sg3_pkg::GRAD_W-1:0]     rsp_grad_y;
   logic [sg3_pkg::DIM_W-1:0]      rsp_center_row;
   logic [sg3_pkg::CCOL_W-1:0]     rsp_center_col;
   logic                           rsp_frame_last;
   logic                           csr_psel = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite = 1'b0;
   logic [sg3_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [sg3_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [sg3_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   sobel_scoreboard_type  sb;
   gradient_result_type   seen_gradient;
   bit                    calm = 1'b0;
   bit                    hold_request = 1'b0;
   int                    hold_left = 0;
   int                    cycle_count = 0;
   int                    register_writes = 0;

   // four 3x3 frames back to back: strong edges in each direction
   logic [sg3_pkg::PIX_W-1:0] step_frames [36] = '{
      8'd255, 8'd255, 8'd255,  8'd0,   8'd0,   8'd0,    8'd0,   8'd0,   8'd0,
      8'd0,   8'd0,   8'd0,    8'd0,   8'd0,   8'd0,    8'd255, 8'd255, 8'd255,
      8'd0,   8'd0,   8'd255,  8'd0,   8'd0,   8'd255,  8'd0,   8'd0,   8'd255,
      8'd255, 8'd0,   8'd0,    8'd255, 8'd0,   8'd0,    8'd255, 8'd0,   8'd0
   };

   sobel_gradient_3x3 #(
      .MAX_WIDTH (MAX_WIDTH)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel      (req_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_grad_x     (rsp_grad_x),
      .rsp_grad_y     (rsp_grad_y),
      .rsp_center_row (rsp_center_row),
      .rsp_center_col (rsp_center_col),
      .rsp_frame_last (rsp_frame_last),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d gradients outstanding",
                  cycle_count, sb.pending_gradients.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // result side: check each accepted beat, then pick next stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen_gradient.grad_x     = rsp_grad_x;
            seen_gradient.grad_y     = rsp_grad_y;
            seen_gradient.center_row = rsp_center_row;
            seen_gradient.center_col = rsp_center_col;
            seen_gradient.frame_last = rsp_frame_last;
            sb.check_gradient(seen_gradient);
         end
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < 10);
         end
      end
   end

   // mostly random values, often the extremes
   function automatic logic [sg3_pkg::PIX_W-1:0] pick_pixel();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return sg3_pkg::PIX_W'($urandom_range(255));
      endcase
   endfunction

   // offer one pixel beat, with random gaps ahead of it
   task automatic send_pixel(input logic [sg3_pkg::PIX_W-1:0] pix);
      while (!calm && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= pix;
      do @(posedge clock); while (req_stall);
      sb.take_pixel(pix);
   endtask

   task automatic stream_pixels(input int count);
      for (int i = 0; i < count; i++) send_pixel(pick_pixel());
   endtask

   // drop valid, wait out all expected beats and the pipeline tail
   task automatic finish_phase();
      req_valid <= 1'b0;
      while (sb.pending_gradients.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // setup phase, access phase held until pready, then an idle phase
   task automatic csr_access(input logic is_write, input logic sel,
                             input logic [sg3_pkg::CSR_DATA_W-1:0] wdata,
                             output logic [sg3_pkg::CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= {sel, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata        = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // write with junk in the unused upper bits, then read it back
   task automatic program_register(input logic sel,
                                   input logic [sg3_pkg::DIM_W-1:0] value);
      logic [sg3_pkg::CSR_DATA_W-1:0] word;
      logic [sg3_pkg::CSR_DATA_W-1:0] readback;
      word                      = $urandom;
      word[sg3_pkg::DIM_W-1:0]  = value;
      csr_access(1'b1, sel, word, readback);
      sb.write_register(sel, word);
      register_writes++;
      csr_access(1'b0, sel, '0, readback);
      if (readback !== sg3_pkg::CSR_DATA_W'(value)) begin
         sb.report_mismatch($sformatf("register %0d reads %h, wrote %h",
                                      sel, readback, value));
      end
   endtask

   task automatic set_geometry(input int w, input int h);
      program_register(sg3_pkg::REG_IMAGE_WIDTH, sg3_pkg::DIM_W'(w));
      program_register(sg3_pkg::REG_IMAGE_HEIGHT, sg3_pkg::DIM_W'(h));
   endtask

   initial begin
      int random_count;
      int phase_idx;
      int w, h, n;

      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // geometry out of reset: a short run, no window completes yet
      stream_pixels(12);
      finish_phase();

      // directed 3x3 frames with full-scale edges
      set_geometry(3, 3);
      foreach (step_frames[i]) send_pixel(step_frames[i]);
      finish_phase();

      // widths and heights below three never give a result
      set_geometry(0, 3);
      stream_pixels(6);
      finish_phase();
      set_geometry(1, 5);
      stream_pixels(9);
      finish_phase();
      set_geometry(2, 4);
      stream_pixels(11);
      finish_phase();
      set_geometry(3, 0);
      stream_pixels(7);
      finish_phase();
      set_geometry(5, 1);
      stream_pixels(12);
      finish_phase();
      set_geometry(4, 2);
      stream_pixels(10);
      finish_phase();

      // random frames, some cut short, a few degenerate ones mixed in
      random_count = 0;
      phase_idx    = 0;
      while (random_count < RANDOM_PIXELS || phase_idx <= 4) begin
         calm = (phase_idx == 4);
         if (phase_idx % 8 == 7) begin
            if ($urandom_range(1)) begin
               set_geometry($urandom_range(2), $urandom_range(12));
            end else begin
               set_geometry($urandom_range(12), $urandom_range(2));
            end
            stream_pixels($urandom_range(4, 20));
         end else begin
            w = $urandom_range(3, 14);
            h = $urandom_range(3, 7);
            if (phase_idx == 2 || calm) begin
               w = 14;
               h = 7;
            end
            set_geometry(w, h);
            n = w * h * (calm ? 2 : (phase_idx == 2) ? 1 : $urandom_range(1, 2));
            if (!calm && phase_idx != 2 && $urandom_range(4) == 0) begin
               n = $urandom_range(1, w * h * 2 - 1);
            end
            // long output hold while pixels keep coming
            if (phase_idx == 2) hold_request = 1'b1;
            stream_pixels(n);
            random_count += n;
         end
         finish_phase();
         phase_idx++;
      end
      calm = 1'b0;

      // width past the line store, a partial row only
      set_geometry(4095, 3);
      stream_pixels(24);
      finish_phase();

      // narrow tall frame, first rows
      set_geometry(3, 4095);
      stream_pixels(3 * 20);
      finish_phase();

      $display("run covered %0d pixel beats, %0d gradient beats, %0d register writes",
               sb.pixels_taken, sb.gradients_checked, register_writes);
      $display("sizes from 3x3 up to 14x7, sub-3 sizes, oversized width, a tall frame, %s",
               "cut frames, and a long output hold with input back-pressure");
      if (sb.mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", sb.mismatch_count);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
